@@ rtl/lvs_pkg.sv @@
// ----------------------------------------------------------------------------
// lvs_pkg
// Shared types, constants and constant functions of the lidar steering block.
// ----------------------------------------------------------------------------
package lvs_pkg;

  localparam int SCAN_DEPTH_DEF   = 2048;
  localparam int DIRECTIONS_DEF   = 30;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_LEN         = 24;

  localparam longint PI_FX       = 205887;
  localparam longint CORDIC_K_Q30 = 652032874;

  localparam int SUM_W  = 36;
  localparam int VEC_W  = 39;
  localparam int ANG_W  = 21;
  localparam int IDX_W  = 3;
  localparam int DATA_W = 20;

  localparam logic [IDX_W-1:0] REG_ANGLE_MIN  = 3'd0;
  localparam logic [IDX_W-1:0] REG_ANGLE_MAX  = 3'd1;
  localparam logic [IDX_W-1:0] REG_ANGLE_STEP = 3'd2;
  localparam logic [IDX_W-1:0] REG_SCAN_LEN   = 3'd3;
  localparam logic [IDX_W-1:0] REG_STOP_DIST  = 3'd4;
  localparam logic [IDX_W-1:0] REG_CLAMP_DIST = 3'd5;
  localparam logic [IDX_W-1:0] REG_STEER_GAIN = 3'd6;

  localparam logic signed [19:0] RST_ANGLE_MIN  = -20'sd154416;
  localparam logic signed [19:0] RST_ANGLE_MAX  = 20'sd154416;
  localparam logic [16:0]        RST_ANGLE_STEP = 17'd285;
  localparam logic [11:0]        RST_SCAN_LEN   = 12'd1081;
  localparam logic [15:0]        RST_STOP_DIST  = 16'd1000;
  localparam logic [15:0]        RST_CLAMP_DIST = 16'd5000;
  localparam logic [11:0]        RST_STEER_GAIN = 12'd256;

  typedef struct packed {
    logic signed [19:0] angle_min;
    logic signed [19:0] angle_max;
    logic [16:0]        angle_step;
    logic [11:0]        scan_length;
    logic [15:0]        stop_dist;
    logic [15:0]        clamp_dist;
    logic [11:0]        steer_gain;
  } cfg_t;

  function automatic int atan_val(int k);
    case (k)
      0:       return 51472;
      1:       return 30386;
      2:       return 16055;
      3:       return 8150;
      4:       return 4091;
      5:       return 2047;
      6:       return 1024;
      7:       return 512;
      8:       return 256;
      9:       return 128;
      10:      return 64;
      11:      return 32;
      12:      return 16;
      13:      return 8;
      14:      return 4;
      15:      return 2;
      16:      return 1;
      default: return 0;
    endcase
  endfunction

  function automatic longint sat16(longint v);
    if (v < -32768) return -32768;
    if (v > 32767) return 32767;
    return v;
  endfunction

  // {cos, sin} in q1.15 of angle z_in
  function automatic logic [31:0] cordic_cs(longint z_in, int steps);
    longint x;
    longint y;
    longint z;
    longint nx;
    longint c;
    longint s;
    x = CORDIC_K_Q30;
    y = 0;
    z = z_in;
    for (int k = 0; k < steps && k < ATAN_LEN; k++) begin
      if (z >= 0) begin
        nx = x - (y >>> k);
        y  = y + (x >>> k);
        z  = z - longint'(atan_val(k));
      end else begin
        nx = x + (y >>> k);
        y  = y - (x >>> k);
        z  = z + longint'(atan_val(k));
      end
      x = nx;
    end
    c = sat16((x + 16384) >>> 15);
    s = sat16((y + 16384) >>> 15);
    return {c[15:0], s[15:0]};
  endfunction

endpackage

@@ rtl/lvs_if.sv @@
// ----------------------------------------------------------------------------
// lvs interfaces
// Sample, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lvs_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] range_mm;
  logic        scan_end;
  modport source (output valid, range_mm, scan_end, input ready);
  modport sink   (input valid, range_mm, scan_end, output ready);
endinterface

interface lvs_out_if;
  logic               valid;
  logic               ready;
  logic signed [19:0] steer_angle;
  logic               go;
  modport source (output valid, steer_angle, go, input ready);
  modport sink   (input valid, steer_angle, go, output ready);
endinterface

interface lvs_cfg_if import lvs_pkg::*;;
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/lvs_ram.sv @@
// ----------------------------------------------------------------------------
// lvs_ram
// Generic simple dual port ram, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lvs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/lvs_queue.sv @@
// ----------------------------------------------------------------------------
// lvs_queue
// Small register queue between the front and back parts.
// ----------------------------------------------------------------------------
module lvs_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] head
);

  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      count;

  assign full      = (count == (PW+1)'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/lvs_front.sv @@
// ----------------------------------------------------------------------------
// lvs_front
// Accepts samples, assigns store positions and tags the end of a scan.
// ----------------------------------------------------------------------------
module lvs_front import lvs_pkg::*; #(
  parameter int SCAN_DEPTH = SCAN_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  lvs_in_if.sink                             samples,
  input  logic                               q_full,
  output logic                               q_push,
  output logic [$clog2(SCAN_DEPTH)+17:0]     q_data
);

  localparam int AW = $clog2(SCAN_DEPTH);

  logic [AW:0] pos;
  logic        room;

  assign room          = (pos < (AW+1)'(SCAN_DEPTH));
  assign samples.ready = !q_full;
  assign q_push        = samples.valid && !q_full;
  assign q_data        = {samples.scan_end, room, pos[AW-1:0], samples.range_mm};

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (q_push) begin
      if (samples.scan_end) begin
        pos <= '0;
      end else if (room) begin
        pos <= pos + 1'b1;
      end
    end
  end

endmodule

@@ rtl/lvs_back.sv @@
// ----------------------------------------------------------------------------
// lvs_back
// Writes the scan store and evaluates a scan into one steering result.
// ----------------------------------------------------------------------------
module lvs_back import lvs_pkg::*; #(
  parameter int SCAN_DEPTH   = SCAN_DEPTH_DEF,
  parameter int DIRECTIONS   = DIRECTIONS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  cfg_t                           cfg,
  input  logic                           q_valid,
  input  logic [$clog2(SCAN_DEPTH)+17:0] q_data,
  output logic                           q_pop,
  lvs_out_if.source                      result
);

  localparam int AW  = $clog2(SCAN_DEPTH);
  localparam int DW  = $clog2(DIRECTIONS);
  localparam int KW  = $clog2(CORDIC_STEPS);
  localparam longint DEN = 2 * (DIRECTIONS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_IDX, S_DIV, S_RD, S_DATA, S_ACC, S_VINIT, S_VEC, S_SCALE, S_SAT, S_OUT
  } state_t;

  logic signed [19:0] ang_tab [DIRECTIONS];
  logic signed [15:0] cos_tab [DIRECTIONS];
  logic signed [15:0] sin_tab [DIRECTIONS];

  for (genvar g = 0; g < DIRECTIONS; g++) begin : g_tab
    localparam longint A  = ((2 * g - (DIRECTIONS - 1)) * PI_FX) / DEN;
    localparam logic [31:0] CS = cordic_cs(A, CORDIC_STEPS);
    localparam logic [63:0] AU = A;
    assign ang_tab[g] = signed'(AU[19:0]);
    assign cos_tab[g] = signed'(CS[31:16]);
    assign sin_tab[g] = signed'(CS[15:0]);
  end

  state_t                    state;
  logic                      front;
  logic [DW-1:0]             dir;
  logic signed [19:0]        cur_ang;
  logic [16:0]               rem;
  logic [19:0]               quo;
  logic [4:0]                dcnt;
  logic signed [32:0]        px;
  logic signed [32:0]        py;
  logic signed [SUM_W-1:0]   sx;
  logic signed [SUM_W-1:0]   sy;
  logic signed [VEC_W-1:0]   vx;
  logic signed [VEC_W-1:0]   vy;
  logic signed [ANG_W-1:0]   vz;
  logic [KW-1:0]             vk;
  logic signed [33:0]        prod;
  logic signed [19:0]        res_steer;
  logic                      res_go;

  logic [15:0]               rd_data;
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  logic                      q_last;
  logic                      q_we;
  logic [AW-1:0]             q_addr;
  logic [15:0]               q_range;

  logic [11:0]               len1;
  logic [16:0]               divisor;
  logic signed [20:0]        diff;
  logic [17:0]               shifted;
  logic [17:0]               trial;
  logic [19:0]               q_len;
  logic [19:0]               q_clamp;
  logic [15:0]               rr;
  logic signed [SUM_W:0]     sx_sum;
  logic signed [SUM_W:0]     sy_sum;
  logic signed [SUM_W-1:0]   sx_sat;
  logic signed [SUM_W-1:0]   sy_sat;
  logic signed [VEC_W-1:0]   xs;
  logic signed [VEC_W-1:0]   ys;
  logic signed [ANG_W-1:0]   atan_k;
  logic signed [34:0]        rounded;
  logic [DW-1:0]             dir_inc;

  assign {q_last, q_we, q_addr, q_range} = q_data;
  assign q_pop = (state == S_IDLE) && q_valid;

  assign len1    = (cfg.scan_length == '0) ? 12'd0 : cfg.scan_length - 12'd1;
  assign divisor = (cfg.angle_step == '0) ? 17'd1 : cfg.angle_step;
  assign diff    = 21'(cur_ang) - 21'(cfg.angle_min);
  assign shifted = {rem, quo[19]};
  assign trial   = shifted - {1'b0, divisor};
  assign q_len   = (quo > {8'd0, len1}) ? {8'd0, len1} : quo;
  assign q_clamp = (q_len > 20'(SCAN_DEPTH - 1)) ? 20'(SCAN_DEPTH - 1) : q_len;
  assign rd_addr = q_clamp[AW-1:0];
  assign rd_en   = (state == S_RD);
  assign rr      = (rd_data > cfg.clamp_dist) ? cfg.clamp_dist : rd_data;
  assign sx_sum  = 37'(sx) + 37'(px);
  assign sy_sum  = 37'(sy) + 37'(py);
  assign sx_sat  = (sx_sum > 37'sh07_ffff_ffff) ? 36'sh7_ffff_ffff :
                   (sx_sum < -37'sh08_0000_0000) ? -36'sh8_0000_0000 : sx_sum[SUM_W-1:0];
  assign sy_sat  = (sy_sum > 37'sh07_ffff_ffff) ? 36'sh7_ffff_ffff :
                   (sy_sum < -37'sh08_0000_0000) ? -36'sh8_0000_0000 : sy_sum[SUM_W-1:0];
  assign xs      = vx >>> vk;
  assign ys      = vy >>> vk;
  assign atan_k  = ANG_W'(atan_val(int'(vk)));
  assign rounded = 35'(prod) + 35'sd128;
  assign dir_inc = dir + 1'b1;

  lvs_ram #(.WIDTH(16), .DEPTH(SCAN_DEPTH)) u_store (
    .clk   (clk),
    .we    (q_pop && q_we),
    .waddr (q_addr),
    .wdata (q_range),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result.valid <= 1'b0;
    end else begin
      if (result.valid && result.ready && state != S_OUT) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid && q_last) begin
            front   <= 1'b1;
            cur_ang <= '0;
            state   <= S_IDX;
          end
        end
        S_IDX: begin
          rem  <= '0;
          dcnt <= '0;
          if (cur_ang < cfg.angle_min) begin
            quo   <= '0;
            state <= S_RD;
          end else if (cur_ang > cfg.angle_max) begin
            quo   <= {8'd0, len1};
            state <= S_RD;
          end else begin
            quo   <= diff[19:0];
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (!trial[17]) begin
            rem <= trial[16:0];
            quo <= {quo[18:0], 1'b1};
          end else begin
            rem <= shifted[16:0];
            quo <= {quo[18:0], 1'b0};
          end
          dcnt <= dcnt + 1'b1;
          if (dcnt == 5'd19) begin
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_DATA;
        end
        S_DATA: begin
          if (front) begin
            if (rd_data < cfg.stop_dist) begin
              res_steer <= '0;
              res_go    <= 1'b0;
              state     <= S_OUT;
            end else begin
              front   <= 1'b0;
              dir     <= '0;
              sx      <= '0;
              sy      <= '0;
              cur_ang <= ang_tab[0];
              state   <= S_IDX;
            end
          end else begin
            px    <= signed'({1'b0, rr}) * cos_tab[dir];
            py    <= signed'({1'b0, rr}) * sin_tab[dir];
            state <= S_ACC;
          end
        end
        S_ACC: begin
          sx <= sx_sat;
          sy <= sy_sat;
          if (dir == DW'(DIRECTIONS - 1)) begin
            state <= S_VINIT;
          end else begin
            dir     <= dir_inc;
            cur_ang <= ang_tab[dir_inc];
            state   <= S_IDX;
          end
        end
        S_VINIT: begin
          vk <= '0;
          if (sx == '0 && sy == '0) begin
            vz    <= '0;
            state <= S_SCALE;
          end else if (sx < 0) begin
            vx    <= -VEC_W'(sx);
            vy    <= -VEC_W'(sy);
            vz    <= (sy >= 0) ? ANG_W'(PI_FX) : -ANG_W'(PI_FX);
            state <= S_VEC;
          end else begin
            vx    <= VEC_W'(sx);
            vy    <= VEC_W'(sy);
            vz    <= '0;
            state <= S_VEC;
          end
        end
        S_VEC: begin
          if (vy >= 0) begin
            vx <= vx + ys;
            vy <= vy - xs;
            vz <= vz + atan_k;
          end else begin
            vx <= vx - ys;
            vy <= vy + xs;
            vz <= vz - atan_k;
          end
          vk <= vk + 1'b1;
          if (vk == KW'(CORDIC_STEPS - 1)) begin
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          prod  <= 34'(vz) * signed'({22'd0, cfg.steer_gain});
          state <= S_SAT;
        end
        S_SAT: begin
          if ((rounded >>> 8) > 35'sd524287) begin
            res_steer <= 20'sd524287;
          end else if ((rounded >>> 8) < -35'sd524288) begin
            res_steer <= -20'sd524288;
          end else begin
            res_steer <= rounded[27:8];
          end
          res_go <= 1'b1;
          state  <= S_OUT;
        end
        S_OUT: begin
          if (!result.valid || result.ready) begin
            result.valid       <= 1'b1;
            result.steer_angle <= res_steer;
            result.go          <= res_go;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/lidar_vector_sum_steering.sv @@
// ----------------------------------------------------------------------------
// lidar_vector_sum_steering
// Reactive steering from one lidar scan by a vector sum of ranges.
// ----------------------------------------------------------------------------
// samples: one range per item, scan_end marks the last sample of a scan.
// result: one item per scan, steer_angle in 2^-16 rad and go.
// cfg: register writes, always ready; they are to be taken while the block
// is idle, a rule the user must keep: the block itself does not enforce it.
// a sample enters a four entry queue in its cycle; the store side drains
// one sample per cycle while no scan is evaluated, so a steady stream then
// runs at one sample per cycle. at scan end the front check and then each
// direction run the one bit per cycle index divider, then the atan2 loop.
// samples keep queueing during evaluation until the queue fills.
// the result sits in an output register; while the receiver stalls,
// evaluation of a following scan waits at its last step.
// reset (synchronous) restores register defaults, empties queue and
// output and sets the store position to zero; the store is not cleared.
// ----------------------------------------------------------------------------
module lidar_vector_sum_steering import lvs_pkg::*; #(
  parameter int SCAN_DEPTH   = SCAN_DEPTH_DEF,
  parameter int DIRECTIONS   = DIRECTIONS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  lvs_in_if.sink     samples,
  lvs_out_if.source  result,
  lvs_cfg_if.sink    cfg
);

  localparam int QW = $clog2(SCAN_DEPTH) + 18;

  cfg_t          regs;
  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_valid;
  logic [QW-1:0] q_in;
  logic [QW-1:0] q_head;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.angle_min   <= RST_ANGLE_MIN;
      regs.angle_max   <= RST_ANGLE_MAX;
      regs.angle_step  <= RST_ANGLE_STEP;
      regs.scan_length <= RST_SCAN_LEN;
      regs.stop_dist   <= RST_STOP_DIST;
      regs.clamp_dist  <= RST_CLAMP_DIST;
      regs.steer_gain  <= RST_STEER_GAIN;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_ANGLE_MIN:  regs.angle_min   <= signed'(cfg.data);
        REG_ANGLE_MAX:  regs.angle_max   <= signed'(cfg.data);
        REG_ANGLE_STEP: regs.angle_step  <= cfg.data[16:0];
        REG_SCAN_LEN:   regs.scan_length <= cfg.data[11:0];
        REG_STOP_DIST:  regs.stop_dist   <= cfg.data[15:0];
        REG_CLAMP_DIST: regs.clamp_dist  <= cfg.data[15:0];
        REG_STEER_GAIN: regs.steer_gain  <= cfg.data[11:0];
        default: ;
      endcase
    end
  end

  lvs_front #(.SCAN_DEPTH(SCAN_DEPTH)) u_front (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_in)
  );

  lvs_queue #(.WIDTH(QW), .DEPTH(4)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  lvs_back #(
    .SCAN_DEPTH   (SCAN_DEPTH),
    .DIRECTIONS   (DIRECTIONS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (regs),
    .q_valid (q_valid),
    .q_data  (q_head),
    .q_pop   (q_pop),
    .result  (result)
  );

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the lidar vector-sum steering block. Scans are
// streamed in as range items; a local model of the store, index mapping,
// cordic and gain stage predicts each steering result, which is compared
// field by field with what the block returns. Config writes happen between
// scan groups while the block is idle, and both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top import lvs_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  STORE_DEPTH = 2048;
  localparam int  NUM_DIRS    = 30;
  localparam int  ROT_STEPS   = 16;
  localparam longint HALF_TURN = 205887;
  localparam longint ROT_GAIN  = 652032874;
  localparam longint ACC_MAX   = 64'sd34359738367;
  localparam longint ACC_MIN   = -64'sd34359738368;
  localparam int  SETTLE_CYCLES = 1000;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [15:0] range_mm;
    logic        scan_end;
  } sample_t;

  typedef struct {
    logic signed [19:0] steer;
    logic               go;
  } steer_t;

  logic clk;
  logic rst;

  lvs_in_if  smp ();
  lvs_out_if res ();
  lvs_cfg_if cfgc ();

  lidar_vector_sum_steering dut (
    .clk     (clk),
    .rst     (rst),
    .samples (smp),
    .result  (res),
    .cfg     (cfgc)
  );

  sample_t sample_q[$];
  steer_t  steer_q[$];
  logic [15:0] scan_mem[STORE_DEPTH];
  int      write_pos;
  cfg_t    model_cfg;
  int      errors;
  int      send_idle_pct;
  int      recv_idle_pct;
  int      hold_cycles;
  longint  cycles;
  int      items_sent;

  function automatic int rot_atan(int k);
    int tab[17];
    tab = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256, 128, 64, 32,
            16, 8, 4, 2, 1};
    return (k < 17) ? tab[k] : 0;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int dir_index(longint a);
    longint len;
    longint stp;
    longint lo;
    longint idx;
    len = (model_cfg.scan_length == 0) ? 1 : longint'(model_cfg.scan_length);
    stp = (model_cfg.angle_step == 0) ? 1 : longint'(model_cfg.angle_step);
    lo  = longint'(model_cfg.angle_min);
    if (a < lo) begin
      idx = 0;
    end else if (a > longint'(model_cfg.angle_max)) begin
      idx = len - 1;
    end else begin
      idx = (a - lo) / stp;
      if (idx > len - 1) idx = len - 1;
    end
    if (idx > STORE_DEPTH - 1) idx = STORE_DEPTH - 1;
    return int'(idx);
  endfunction

  function automatic void rotate_cs(longint z, output longint c, output longint s);
    longint x;
    longint y;
    longint nx;
    x = ROT_GAIN;
    y = 0;
    for (int k = 0; k < ROT_STEPS; k++) begin
      if (z >= 0) begin
        nx = x - (y >>> k); y = y + (x >>> k); z = z - rot_atan(k);
      end else begin
        nx = x + (y >>> k); y = y - (x >>> k); z = z + rot_atan(k);
      end
      x = nx;
    end
    c = clip((x + 16384) >>> 15, -32768, 32767);
    s = clip((y + 16384) >>> 15, -32768, 32767);
  endfunction

  function automatic longint heading(longint y, longint x);
    longint z;
    longint nx;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? HALF_TURN : -HALF_TURN;
      x = -x;
      y = -y;
    end
    for (int k = 0; k < ROT_STEPS; k++) begin
      if (y >= 0) begin
        nx = x + (y >>> k); y = y - (x >>> k); z = z + rot_atan(k);
      end else begin
        nx = x - (y >>> k); y = y + (x >>> k); z = z - rot_atan(k);
      end
      x = nx;
    end
    return z;
  endfunction

  function automatic void take_sample(sample_t it);
    steer_t  exp_r;
    longint  sx;
    longint  sy;
    longint  a;
    longint  rr;
    longint  c;
    longint  s;
    longint  ang;
    if (write_pos < STORE_DEPTH) begin
      scan_mem[write_pos] = it.range_mm;
      write_pos++;
    end
    if (!it.scan_end) return;
    write_pos = 0;
    exp_r.steer = '0;
    exp_r.go = 1'b0;
    if (scan_mem[dir_index(0)] >= model_cfg.stop_dist) begin
      sx = 0;
      sy = 0;
      for (int i = 0; i < NUM_DIRS; i++) begin
        a = (longint'(2 * i - (NUM_DIRS - 1)) * HALF_TURN) / (2 * (NUM_DIRS - 1));
        rr = scan_mem[dir_index(a)];
        if (rr > longint'(model_cfg.clamp_dist)) rr = model_cfg.clamp_dist;
        rotate_cs(a, c, s);
        sx = clip(sx + rr * c, ACC_MIN, ACC_MAX);
        sy = clip(sy + rr * s, ACC_MIN, ACC_MAX);
      end
      ang = heading(sy, sx);
      exp_r.steer = 20'(clip((ang * longint'(model_cfg.steer_gain) + 128) >>> 8,
                             -524288, 524287));
      exp_r.go = 1'b1;
    end
    steer_q.push_back(exp_r);
  endfunction

  task automatic report(string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // sample driver
  always @(posedge clk) begin
    if (rst) begin
      smp.valid <= 1'b0;
    end else begin
      if (smp.valid && smp.ready) begin
        take_sample(sample_q.pop_front());
      end
      if (!smp.valid || smp.ready) begin
        if (sample_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          smp.valid    <= 1'b1;
          smp.range_mm <= sample_q[0].range_mm;
          smp.scan_end <= sample_q[0].scan_end;
        end else begin
          smp.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    steer_t got_exp;
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (steer_q.size() == 0) begin
          report($sformatf("unexpected item steer %0d go %0b", res.steer_angle, res.go));
        end else begin
          got_exp = steer_q.pop_front();
          if (res.steer_angle !== got_exp.steer)
            report($sformatf("steer_angle %0d, want %0d", res.steer_angle, got_exp.steer));
          if (res.go !== got_exp.go)
            report($sformatf("go %0b, want %0b", res.go, got_exp.go));
        end
      end
      res.ready <= (hold_cycles > 0) ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    @(posedge clk);
    cfgc.valid <= 1'b1;
    cfgc.index <= idx;
    cfgc.data  <= val;
    @(posedge clk);
    while (!cfgc.ready) @(posedge clk);
    cfgc.valid <= 1'b0;
    case (idx)
      REG_ANGLE_MIN:  model_cfg.angle_min  = val;
      REG_ANGLE_MAX:  model_cfg.angle_max  = val;
      REG_ANGLE_STEP: model_cfg.angle_step = val[16:0];
      REG_SCAN_LEN:   model_cfg.scan_length = val[11:0];
      REG_STOP_DIST:  model_cfg.stop_dist  = val[15:0];
      REG_CLAMP_DIST: model_cfg.clamp_dist = val[15:0];
      REG_STEER_GAIN: model_cfg.steer_gain = val[11:0];
      default: ;
    endcase
  endtask

  task automatic load_cfg(int amin, int amax, int stp, int len, int stop, int clamp,
                          int gain);
    write_reg(REG_ANGLE_MIN, DATA_W'(amin));
    write_reg(REG_ANGLE_MAX, DATA_W'(amax));
    write_reg(REG_ANGLE_STEP, DATA_W'(stp));
    write_reg(REG_SCAN_LEN, DATA_W'(len));
    write_reg(REG_STOP_DIST, DATA_W'(stop));
    write_reg(REG_CLAMP_DIST, DATA_W'(clamp));
    write_reg(REG_STEER_GAIN, DATA_W'(gain));
  endtask

  task automatic drain();
    while (sample_q.size() > 0 || smp.valid || steer_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_sample(int r, bit last);
    sample_t it;
    it.range_mm = 16'(r);
    it.scan_end = last;
    sample_q.push_back(it);
    items_sent++;
  endtask

  task automatic push_scan(int n, int lo, int hi);
    for (int i = 0; i < n; i++) push_sample($urandom_range(hi, lo), i == n - 1);
  endtask

  task automatic random_cfg();
    int amin;
    int amax;
    int stp;
    int len;
    amin = -int'($urandom_range(262144));
    amax = int'($urandom_range(262144));
    if ($urandom_range(9) == 0) begin
      amin = int'($urandom_range(262144));
      amax = -int'($urandom_range(262144));
    end
    len = $urandom_range(64, 1);
    case ($urandom_range(9))
      0: len = 0;
      1: len = 64;
      default: ;
    endcase
    stp = $urandom_range(65536, 1);
    if ($urandom_range(3) == 0) stp = $urandom_range(8000, 1);
    if ($urandom_range(9) == 0) stp = 0;
    load_cfg(amin, amax, stp, len, $urandom_range(3000), $urandom_range(65535),
             $urandom_range(4095));
  endtask

  initial begin
    int target;
    int base;
    int lim;
    smp.valid = 1'b0;
    smp.range_mm = '0;
    smp.scan_end = 1'b0;
    res.ready = 1'b0;
    cfgc.valid = 1'b0;
    cfgc.index = '0;
    cfgc.data = '0;
    errors = 0;
    cycles = 0;
    hold_cycles = 0;
    items_sent = 0;
    write_pos = 0;
    send_idle_pct = 17;
    recv_idle_pct = 84;
    model_cfg = '{RST_ANGLE_MIN, RST_ANGLE_MAX, RST_ANGLE_STEP, RST_SCAN_LEN,
                  RST_STOP_DIST, RST_CLAMP_DIST, RST_STEER_GAIN};
    rst = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // fill the store entries that every later scan reads, wide field of view
    load_cfg(-262144, 262144, 256, 64, 0, 5000, 256);
    push_scan(64, 0, 65535);
    drain();

    load_cfg(-102943, 102943, 6434, 32, 0, 65535, 4095);
    push_scan(32, 65535, 65535);
    push_scan(32, 0, 0);
    for (int i = 0; i < 32; i++) push_sample((i == 0 || i == 31) ? 40000 : 0, i == 31);
    drain();
    load_cfg(-102943, 102943, 6434, 32, 1000, 5000, 0);
    push_scan(32, 0, 500);
    push_scan(3, 1000, 9000);
    drain();
    load_cfg(102943, -102943, 0, 0, 65535, 0, 256);
    push_scan(5, 65535, 65535);
    push_scan(4, 0, 65535);
    drain();

    target = 1950;
    base = items_sent;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 17 : ((ph == 1) ? 84 : 0);
      recv_idle_pct = (ph == 0) ? 84 : ((ph == 1) ? 17 : 0);
      if (ph == 0) hold_cycles = 3000;
      lim = base + ((target - base) * (ph + 1)) / 3;
      while (items_sent < lim) begin
        random_cfg();
        for (int k = 0; k < 6 && items_sent < lim; k++) begin
          if ($urandom_range(1)) push_scan($urandom_range(60, 1), 0, 65535);
          else push_scan($urandom_range(60, 1), 0, 6000);
          while (sample_q.size() > 20) @(posedge clk);
        end
        drain();
      end
    end

    drain();
    if (steer_q.size() > 0) report($sformatf("%0d items never came", steer_q.size()));
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/lvs_pkg.sv
rtl/lvs_if.sv
rtl/lvs_ram.sv
rtl/lvs_queue.sv
rtl/lvs_front.sv
rtl/lvs_back.sv
rtl/lidar_vector_sum_steering.sv
tb/tb_top.sv
